### hw/rtl/fspu_pkg.sv
package fspu_pkg;

  localparam logic [4:0] FN_PUSH_D = 5'd0;
  localparam logic [4:0] FN_PUSH_R = 5'd1;
  localparam logic [4:0] FN_WR_CODE = 5'd2;
  localparam logic [4:0] FN_WR_STR = 5'd3;
  localparam logic [4:0] FN_ADD = 5'd4;
  localparam logic [4:0] FN_SUB = 5'd5;
  localparam logic [4:0] FN_MUL = 5'd6;
  localparam logic [4:0] FN_PRINT = 5'd7;
  localparam logic [4:0] FN_LIT = 5'd8;
  localparam logic [4:0] FN_FIN = 5'd9;
  localparam logic [4:0] FN_IF = 5'd10;
  localparam logic [4:0] FN_ELSE = 5'd11;
  localparam logic [4:0] FN_EQUAL = 5'd12;
  localparam logic [4:0] FN_DUP = 5'd13;
  localparam logic [4:0] FN_DROP = 5'd14;
  localparam logic [4:0] FN_SWAP = 5'd15;
  localparam logic [4:0] FN_COUNT = 5'd16;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUNDER = 2'd1;
  localparam logic [1:0] ST_RUNDER = 2'd2;
  localparam logic [1:0] ST_OVF = 2'd3;

  localparam int IN_BITS = 48;
  localparam int OUT_BITS = 48;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MOD,
    S_EXEC,
    S_WB2
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_start;
    logic mem_go;
    logic exec;
    logic wb2;
  } cmd_t;

  typedef struct packed {
    logic needs_mem;
    logic needs_wb2;
    logic mod_ready;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/fspu_addr_mod.sv
module fspu_addr_mod #(
  parameter int DIVISOR = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [31:0]                  src,
  output logic                         busy,
  output logic [$clog2(DIVISOR)-1:0]   rem
);

  localparam int AW = $clog2(DIVISOR);
  localparam bit POW2 = (DIVISOR & (DIVISOR - 1)) == 0;
  // floor(2^(32+AW) / DIVISOR), always in [2^32, 2^33)
  localparam logic [32:0] RECIP = 33'((65'd1 << (32 + AW)) / 65'(DIVISOR));

  logic [AW-1:0]  rem_r;
  logic [31:0]    src_r;
  logic [64:0]    prod_r;
  logic [AW:0]    part_r;
  logic [1:0]     stage_r;
  logic [63:0]    mul_lo;
  logic [32-AW:0] quo;
  logic [31:0]    back;

  // reciprocal quotient is low by at most one, so a single compare and
  // subtract finishes the remainder
  assign mul_lo = src_r * RECIP[31:0];
  assign quo    = prod_r[64:32+AW];
  assign back   = 32'(quo) * 32'(DIVISOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 2'd0;
    end else if (start) begin
      if (POW2) begin
        rem_r   <= src[AW-1:0];
        stage_r <= 2'd0;
      end else begin
        src_r   <= src;
        stage_r <= 2'd1;
      end
    end else begin
      case (stage_r)
        2'd1: begin
          prod_r  <= {1'b0, mul_lo} + {1'b0, src_r, 32'd0};
          stage_r <= 2'd2;
        end
        2'd2: begin
          part_r  <= (AW+1)'(src_r - back);
          stage_r <= 2'd3;
        end
        2'd3: begin
          if (part_r >= (AW+1)'(DIVISOR)) begin
            rem_r <= AW'(part_r - (AW+1)'(DIVISOR));
          end else begin
            rem_r <= part_r[AW-1:0];
          end
          stage_r <= 2'd0;
        end
        default: begin
          stage_r <= 2'd0;
        end
      endcase
    end
  end

  assign busy = stage_r != 2'd0;
  assign rem  = rem_r;

endmodule

### hw/rtl/fspu_ctrl.sv
module fspu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  fspu_pkg::sts_t sts,
  output fspu_pkg::cmd_t cmd
);

  fspu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fspu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      fspu_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = fspu_pkg::S_READ;
        end
      end
      fspu_pkg::S_READ: begin
        if (sts.needs_mem) begin
          cmd.mod_start = 1'b1;
          state_nxt     = fspu_pkg::S_MOD;
        end else begin
          state_nxt = fspu_pkg::S_EXEC;
        end
      end
      fspu_pkg::S_MOD: begin
        if (sts.mod_ready) begin
          cmd.mem_go = 1'b1;
          state_nxt  = fspu_pkg::S_EXEC;
        end
      end
      fspu_pkg::S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = sts.needs_wb2 ? fspu_pkg::S_WB2 : fspu_pkg::S_IDLE;
        end
      end
      fspu_pkg::S_WB2: begin
        cmd.wb2   = 1'b1;
        state_nxt = fspu_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fspu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/fspu_datapath.sv
module fspu_datapath #(
  parameter int DATA_DEPTH   = 64,
  parameter int RETURN_DEPTH = 32,
  parameter int CODE_WORDS   = 1024,
  parameter int STRING_WORDS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fspu_pkg::cmd_t                  cmd,
  input  logic [fspu_pkg::IN_BITS-1:0]    in_tdata,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [fspu_pkg::OUT_BITS-1:0]   out_tdata,
  output fspu_pkg::sts_t                  sts
);

  localparam int DW  = $clog2(DATA_DEPTH + 1);
  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int RW  = $clog2(RETURN_DEPTH + 1);
  localparam int RAW = $clog2(RETURN_DEPTH);
  localparam int CAW = $clog2(CODE_WORDS);
  localparam int SAW = $clog2(STRING_WORDS);

  logic [31:0] d_mem [DATA_DEPTH];
  logic [31:0] r_mem [RETURN_DEPTH];
  logic [31:0] c_mem [CODE_WORDS];
  logic [31:0] s_mem [STRING_WORDS];

  logic [4:0]  func_r;
  logic [31:0] value_r;
  logic [9:0]  addr_r;
  logic [DW-1:0] dc_r, dc_nxt, dc_m1, dc_m2;
  logic [RW-1:0] rc_r, rc_nxt, rc_m1;
  logic [31:0] dtop_q, dsec_q, rtop_q, code_q, str_q;

  logic        out_tvalid_r;
  logic [fspu_pkg::OUT_BITS-1:0] out_tdata_r;

  logic        w2_en_r;
  logic [DAW-1:0] w2_idx_r;
  logic [31:0] w2_dat_r;

  logic [31:0] mod_src, mem_q, prod;
  logic        c_busy, s_busy;
  logic [CAW-1:0] c_idx;
  logic [SAW-1:0] s_idx;

  logic [1:0]  st;
  logic        pv;
  logic [31:0] pval;
  logic        dw_en, rw_en, w2_en;
  logic [DAW-1:0] dw_idx, w2_idx;
  logic [RAW-1:0] rw_idx;
  logic [31:0] dw_dat, rw_dat, w2_dat;
  logic        dfull, rfull;

  assign dc_m1 = dc_r - DW'(1);
  assign dc_m2 = dc_r - DW'(2);
  assign rc_m1 = rc_r - RW'(1);
  assign dfull = dc_r >= DW'(DATA_DEPTH);
  assign rfull = rc_r >= RW'(RETURN_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_tdata[4:0];
      value_r <= in_tdata[36:5];
      addr_r  <= in_tdata[46:37];
      dtop_q  <= d_mem[dc_m1[DAW-1:0]];
      dsec_q  <= d_mem[dc_m2[DAW-1:0]];
      rtop_q  <= r_mem[rc_m1[RAW-1:0]];
    end
  end

  always_comb begin
    case (func_r)
      fspu_pkg::FN_WR_CODE, fspu_pkg::FN_WR_STR: mod_src = {22'd0, addr_r};
      fspu_pkg::FN_COUNT:                         mod_src = dtop_q;
      default:                                    mod_src = rtop_q + 32'd1;
    endcase
  end

  fspu_addr_mod #(.DIVISOR(CODE_WORDS)) u_code_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mod_start),
    .src   (mod_src),
    .busy  (c_busy),
    .rem   (c_idx)
  );

  fspu_addr_mod #(.DIVISOR(STRING_WORDS)) u_str_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mod_start),
    .src   (mod_src),
    .busy  (s_busy),
    .rem   (s_idx)
  );

  always_ff @(posedge clk) begin
    if (cmd.mem_go) begin
      if (func_r == fspu_pkg::FN_WR_CODE) begin
        c_mem[c_idx] <= value_r;
      end
      code_q <= c_mem[c_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_go) begin
      if (func_r == fspu_pkg::FN_WR_STR) begin
        s_mem[s_idx] <= value_r;
      end
      str_q <= s_mem[s_idx];
    end
  end

  assign mem_q = (func_r == fspu_pkg::FN_COUNT) ? str_q : code_q;
  assign prod  = dsec_q * dtop_q;

  // word execution; dsec_q is the second entry, dtop_q the top
  always_comb begin
    st     = fspu_pkg::ST_OK;
    pv     = 1'b0;
    pval   = '0;
    dc_nxt = dc_r;
    rc_nxt = rc_r;
    dw_en  = 1'b0;
    dw_idx = dc_m2[DAW-1:0];
    dw_dat = '0;
    rw_en  = 1'b0;
    rw_idx = rc_m1[RAW-1:0];
    rw_dat = '0;
    w2_en  = 1'b0;
    w2_idx = dc_m1[DAW-1:0];
    w2_dat = '0;
    case (func_r)
      fspu_pkg::FN_PUSH_D: begin
        if (dfull) begin
          st = fspu_pkg::ST_OVF;
        end else begin
          dw_en  = 1'b1;
          dw_idx = dc_r[DAW-1:0];
          dw_dat = value_r;
          dc_nxt = dc_r + DW'(1);
        end
      end
      fspu_pkg::FN_PUSH_R: begin
        if (rfull) begin
          st = fspu_pkg::ST_OVF;
        end else begin
          rw_en  = 1'b1;
          rw_idx = rc_r[RAW-1:0];
          rw_dat = value_r;
          rc_nxt = rc_r + RW'(1);
        end
      end
      fspu_pkg::FN_ADD, fspu_pkg::FN_MUL, fspu_pkg::FN_EQUAL, fspu_pkg::FN_SWAP: begin
        if (dc_r < DW'(2)) begin
          st = fspu_pkg::ST_DUNDER;
        end else begin
          dw_en  = 1'b1;
          dc_nxt = dc_m1;
          case (func_r)
            fspu_pkg::FN_ADD: dw_dat = dsec_q + dtop_q;
            fspu_pkg::FN_MUL: dw_dat = prod;
            fspu_pkg::FN_EQUAL: dw_dat = {31'd0, dsec_q == dtop_q};
            default: begin
              dw_dat = dtop_q;
              w2_en  = 1'b1;
              w2_dat = dsec_q;
              dc_nxt = dc_r;
            end
          endcase
        end
      end
      fspu_pkg::FN_SUB: begin
        if (dc_r == '0) begin
          st = fspu_pkg::ST_DUNDER;
        end else if (dc_r == DW'(1)) begin
          dw_en  = 1'b1;
          dw_idx = '0;
          dw_dat = 32'd0 - dtop_q;
        end else begin
          dw_en  = 1'b1;
          dw_dat = dsec_q - dtop_q;
          dc_nxt = dc_m1;
        end
      end
      fspu_pkg::FN_PRINT: begin
        if (dc_r == '0) begin
          st = fspu_pkg::ST_DUNDER;
        end else begin
          pv     = 1'b1;
          pval   = dtop_q;
          dc_nxt = dc_m1;
        end
      end
      fspu_pkg::FN_LIT: begin
        if (rc_r == '0) begin
          st     = fspu_pkg::ST_RUNDER;
          dc_nxt = '0;
        end else if (dfull) begin
          st = fspu_pkg::ST_OVF;
        end else begin
          rw_en  = 1'b1;
          rw_dat = rtop_q + 32'd1;
          dw_en  = 1'b1;
          dw_idx = dc_r[DAW-1:0];
          dw_dat = mem_q;
          dc_nxt = dc_r + DW'(1);
        end
      end
      fspu_pkg::FN_FIN: begin
        if (rc_r == '0) begin
          st     = fspu_pkg::ST_RUNDER;
          dc_nxt = '0;
        end else begin
          rc_nxt = rc_m1;
        end
      end
      fspu_pkg::FN_IF: begin
        if (dc_r == '0) begin
          st = fspu_pkg::ST_DUNDER;
        end else if (rc_r == '0) begin
          st     = fspu_pkg::ST_RUNDER;
          dc_nxt = '0;
        end else begin
          dc_nxt = dc_m1;
          rw_en  = 1'b1;
          rw_dat = (dtop_q != '0) ? rtop_q + 32'd1 : mem_q;
        end
      end
      fspu_pkg::FN_ELSE: begin
        if (rc_r == '0) begin
          st     = fspu_pkg::ST_RUNDER;
          dc_nxt = '0;
        end else begin
          rw_en  = 1'b1;
          rw_dat = mem_q;
        end
      end
      fspu_pkg::FN_DUP: begin
        if (dc_r == '0) begin
          st = fspu_pkg::ST_DUNDER;
        end else if (dfull) begin
          st = fspu_pkg::ST_OVF;
        end else begin
          dw_en  = 1'b1;
          dw_idx = dc_r[DAW-1:0];
          dw_dat = dtop_q;
          dc_nxt = dc_r + DW'(1);
        end
      end
      fspu_pkg::FN_DROP: begin
        if (dc_r == '0) begin
          st = fspu_pkg::ST_DUNDER;
        end else begin
          dc_nxt = dc_m1;
        end
      end
      fspu_pkg::FN_COUNT: begin
        if (dc_r == '0) begin
          st = fspu_pkg::ST_DUNDER;
        end else if (dfull) begin
          st = fspu_pkg::ST_OVF;
        end else begin
          dw_en  = 1'b1;
          dw_idx = dc_m1[DAW-1:0];
          dw_dat = dtop_q + 32'd1;
          w2_en  = 1'b1;
          w2_idx = dc_r[DAW-1:0];
          w2_dat = mem_q;
          dc_nxt = dc_r + DW'(1);
        end
      end
      default: begin
        st = fspu_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (dw_en) begin
        d_mem[dw_idx] <= dw_dat;
      end
      if (rw_en) begin
        r_mem[rw_idx] <= rw_dat;
      end
      w2_idx_r <= w2_idx;
      w2_dat_r <= w2_dat;
    end else if (cmd.wb2 && w2_en_r) begin
      d_mem[w2_idx_r] <= w2_dat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r         <= '0;
      rc_r         <= '0;
      w2_en_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        dc_r         <= dc_nxt;
        rc_r         <= rc_nxt;
        w2_en_r      <= w2_en;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_tdata_r <= {6'(rc_nxt), 7'(dc_nxt), pval, pv, st};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign sts.needs_mem = func_r == fspu_pkg::FN_WR_CODE || func_r == fspu_pkg::FN_WR_STR
                      || func_r == fspu_pkg::FN_LIT || func_r == fspu_pkg::FN_IF
                      || func_r == fspu_pkg::FN_ELSE || func_r == fspu_pkg::FN_COUNT;
  assign sts.needs_wb2 = func_r == fspu_pkg::FN_SWAP || func_r == fspu_pkg::FN_COUNT;
  assign sts.mod_ready = !c_busy && !s_busy;
  assign sts.out_free  = !out_tvalid_r || out_tready;

  a_dc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dc_r <= DW'(DATA_DEPTH))
    else $error("data stack count beyond depth");

  a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= RW'(RETURN_DEPTH))
    else $error("return stack count beyond depth");

  a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_tvalid_r || out_tready))
    else $error("result overwritten before transfer");

  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && pv |-> st == fspu_pkg::ST_OK)
    else $error("print with error status");

  a_runder_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && st == fspu_pkg::ST_RUNDER |=> dc_r == '0 && rc_r == '0)
    else $error("return underflow left stacks");

endmodule

### hw/rtl/forth_stack_primitive_unit.sv
// Executes one Forth primitive word per input transfer and returns one result
// transfer per word. Stack-only words go from acceptance to result through
// the steps (accept with stack-top read, operand register, execute); swap and
// count add a second data-stack write step. Words that touch code or string
// memory (write code, write string, lit, if, else, count) add the address
// reduction, a direct low-bit remainder when CODE_WORDS and STRING_WORDS are
// powers of two, otherwise the reciprocal remainder unit. Stack memories have
// one write port, which is why swap and count need the extra write step. A pending
// result is held in the output register while the next word is accepted.
module forth_stack_primitive_unit #(
  parameter int DATA_DEPTH   = 64,
  parameter int RETURN_DEPTH = 32,
  parameter int CODE_WORDS   = 1024,
  parameter int STRING_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // func[4:0], value[36:5], address[46:37]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], print_valid[2], print_value[34:3],
                                  // data_depth[41:35], return_depth[47:42]
);

  fspu_pkg::cmd_t cmd;
  fspu_pkg::sts_t sts;

  fspu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fspu_datapath #(
    .DATA_DEPTH   (DATA_DEPTH),
    .RETURN_DEPTH (RETURN_DEPTH),
    .CODE_WORDS   (CODE_WORDS),
    .STRING_WORDS (STRING_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .sts        (sts)
  );

endmodule
